>>> src/srdiv_pkg.sv
// shared types for the signed restoring divider pipeline
package srdiv_pkg;

    typedef struct packed {
        logic neg;
        logic sat;
    } srdiv_flags_t;

endpackage

>>> src/srdiv_prep.sv
// input stage: operand magnitudes, result sign and saturation detection
module srdiv_prep #(
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_vld,
    input  logic [WIDTH-1:0]         dividend,
    input  logic [WIDTH-1:0]         divisor,
    output logic                     out_vld,
    output logic [WIDTH-1:0]         out_num,
    output logic [WIDTH-1:0]         out_den,
    output srdiv_pkg::srdiv_flags_t  out_flags
);
    import srdiv_pkg::*;

    localparam logic [WIDTH-1:0] SIGN_MIN = {1'b1, {(WIDTH-1){1'b0}}};
    localparam logic [WIDTH-1:0] ALL_ONES = {WIDTH{1'b1}};

    logic         vld_reg;
    logic [WIDTH-1:0] num_reg, num_next;
    logic [WIDTH-1:0] den_reg, den_next;
    srdiv_flags_t flags_reg, flags_next;

    always_comb begin
        num_next       = dividend[WIDTH-1] ? (~dividend + WIDTH'(1)) : dividend;
        den_next       = divisor[WIDTH-1]  ? (~divisor + WIDTH'(1))  : divisor;
        flags_next.neg = dividend[WIDTH-1] ^ divisor[WIDTH-1];
        flags_next.sat = (divisor == '0) || (dividend == SIGN_MIN && divisor == ALL_ONES);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg   <= num_next;
            den_reg   <= den_next;
            flags_reg <= flags_next;
        end
    end

    assign out_vld   = vld_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_flags = flags_reg;

endmodule

>>> src/srdiv_step.sv
// one restoring division step: one quotient bit per register stage
module srdiv_step #(
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_vld,
    input  logic [WIDTH-1:0]         in_rem,
    input  logic [WIDTH-1:0]         in_num,
    input  logic [WIDTH-1:0]         in_den,
    input  srdiv_pkg::srdiv_flags_t  in_flags,
    output logic                     out_vld,
    output logic [WIDTH-1:0]         out_rem,
    output logic [WIDTH-1:0]         out_num,
    output logic [WIDTH-1:0]         out_den,
    output srdiv_pkg::srdiv_flags_t  out_flags
);
    import srdiv_pkg::*;

    logic             vld_reg;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] num_reg, num_next;
    logic [WIDTH-1:0] den_reg;
    srdiv_flags_t     flags_reg;
    logic [WIDTH-1:0] rem_sh;
    logic [WIDTH:0]   diff;

    // partial remainder stays below the divisor, so the shifted value fits
    always_comb begin
        rem_sh = {in_rem[WIDTH-2:0], in_num[WIDTH-1]};
        diff   = {1'b0, rem_sh} - {1'b0, in_den};
        if (!diff[WIDTH]) begin
            rem_next = diff[WIDTH-1:0];
            num_next = {in_num[WIDTH-2:0], 1'b1};
        end else begin
            rem_next = rem_sh;
            num_next = {in_num[WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg   <= rem_next;
            num_reg   <= num_next;
            den_reg   <= in_den;
            flags_reg <= in_flags;
        end
    end

    assign out_vld   = vld_reg;
    assign out_rem   = rem_reg;
    assign out_num   = num_reg;
    assign out_den   = den_reg;
    assign out_flags = flags_reg;

endmodule

>>> src/srdiv_post.sv
// output stage: sign fix-up, saturation and output register
module srdiv_post #(
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_vld,
    input  logic [WIDTH-1:0]         in_quo,
    input  srdiv_pkg::srdiv_flags_t  in_flags,
    output logic                     out_vld,
    output logic [WIDTH-1:0]         out_quo
);
    import srdiv_pkg::*;

    localparam logic [WIDTH-1:0] MAX_POS = {1'b0, {(WIDTH-1){1'b1}}};

    logic             vld_reg;
    logic [WIDTH-1:0] quo_reg, quo_next;

    always_comb begin
        if (in_flags.sat) begin
            quo_next = MAX_POS;
        end else if (in_flags.neg) begin
            quo_next = ~in_quo + WIDTH'(1);
        end else begin
            quo_next = in_quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= quo_next;
        end
    end

    assign out_vld = vld_reg;
    assign out_quo = quo_reg;

endmodule

>>> src/signed_restoring_divider_unit.sv
// top level of the pipelined signed restoring divider
// Divides a signed dividend by a signed divisor and returns the quotient truncated
// toward zero; a zero divisor and the most negative value divided by minus one both
// give the largest positive value. Unless the result side stalls, the unit takes one
// operand pair per cycle; each quotient passes through the stages in order:
// one input stage forms the magnitudes, WIDTH restoring stages each produce one
// quotient bit, and one output stage applies the sign. Back-pressure on the result
// side holds the whole pipeline in place.
module signed_restoring_divider_unit #(
    parameter  int WIDTH    = 32,
    localparam int S_DATA_W = ((2 * WIDTH + 7) / 8) * 8,
    localparam int M_DATA_W = ((WIDTH + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // dividend, divisor
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // quotient
);
    import srdiv_pkg::*;

    logic             pipe_en;
    logic [WIDTH:0]   stg_vld;
    logic [WIDTH-1:0] stg_rem   [WIDTH+1];
    logic [WIDTH-1:0] stg_num   [WIDTH+1];
    logic [WIDTH-1:0] stg_den   [WIDTH+1];
    srdiv_flags_t     stg_flags [WIDTH+1];
    logic [WIDTH-1:0] quo;

    assign pipe_en  = !m_tvalid || m_tready;
    assign s_tready = pipe_en;

    srdiv_prep #(.WIDTH(WIDTH)) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_vld    (s_tvalid),
        .dividend  (s_tdata[WIDTH-1:0]),
        .divisor   (s_tdata[2*WIDTH-1:WIDTH]),
        .out_vld   (stg_vld[0]),
        .out_num   (stg_num[0]),
        .out_den   (stg_den[0]),
        .out_flags (stg_flags[0])
    );

    assign stg_rem[0] = '0;

    for (genvar i = 0; i < WIDTH; i++) begin : g_step
        srdiv_step #(.WIDTH(WIDTH)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (pipe_en),
            .in_vld    (stg_vld[i]),
            .in_rem    (stg_rem[i]),
            .in_num    (stg_num[i]),
            .in_den    (stg_den[i]),
            .in_flags  (stg_flags[i]),
            .out_vld   (stg_vld[i+1]),
            .out_rem   (stg_rem[i+1]),
            .out_num   (stg_num[i+1]),
            .out_den   (stg_den[i+1]),
            .out_flags (stg_flags[i+1])
        );
    end

    srdiv_post #(.WIDTH(WIDTH)) u_post (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (pipe_en),
        .in_vld   (stg_vld[WIDTH]),
        .in_quo   (stg_num[WIDTH]),
        .in_flags (stg_flags[WIDTH]),
        .out_vld  (m_tvalid),
        .out_quo  (quo)
    );

    assign m_tdata = M_DATA_W'(quo);

    // a stall freezes every stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(stg_vld) && $stable(m_tvalid))
        else $error("pipeline moved during stall");

    // valid bits advance one stage per enabled cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_en |=> stg_vld[WIDTH:1] == $past(stg_vld[WIDTH-1:0])
                    && m_tvalid == $past(stg_vld[WIDTH]))
        else $error("valid bit lost or repeated in pipeline");

    // a transfer enters the first stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> stg_vld[0])
        else $error("accepted transfer not captured");

    // saturated items leave as the largest positive value
    assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_en && stg_vld[WIDTH] && stg_flags[WIDTH].sat
        |=> quo == {1'b0, {(WIDTH-1){1'b1}}})
        else $error("saturation value wrong");

endmodule

>>> dv/signed_restoring_divider_unit_tb.sv
// self-checking testbench for the pipelined signed restoring divider
module signed_restoring_divider_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIDTH = 32;
    localparam int S_DATA_W = ((2 * WIDTH + 7) / 8) * 8;
    localparam int M_DATA_W = ((WIDTH + 7) / 8) * 8;
    localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH - 1){1'b0}}};
    localparam logic [WIDTH-1:0] MOST_POS = {1'b0, {(WIDTH - 1){1'b1}}};
    localparam logic [WIDTH-1:0] MINUS_ONE = {WIDTH{1'b1}};
    localparam int RANDOM_PAIRS = 1880;
    localparam int BLOCK_PAIRS = 100;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct {
        logic [WIDTH-1:0] dividend;
        logic [WIDTH-1:0] divisor;
        logic [WIDTH-1:0] quotient;
    } division_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;   // dividend, divisor
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;        // quotient

    bit steady = 1'b0;
    int cycles = 0;

    signed_restoring_divider_unit #(.WIDTH(WIDTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [WIDTH-1:0] divide_toward_zero(logic [WIDTH-1:0] dividend,
                                                            logic [WIDTH-1:0] divisor);
        logic [WIDTH-1:0] num_mag;
        logic [WIDTH-1:0] den_mag;
        logic [WIDTH:0]   partial;
        logic [WIDTH-1:0] quot;
        if (divisor == '0 || (dividend == MOST_NEG && divisor == MINUS_ONE)) begin
            return MOST_POS;
        end
        num_mag = dividend[WIDTH-1] ? -dividend : dividend;
        den_mag = divisor[WIDTH-1] ? -divisor : divisor;
        partial = '0;
        quot = '0;
        for (int i = WIDTH - 1; i >= 0; i--) begin
            partial = {partial[WIDTH-1:0], num_mag[i]};
            if (partial >= {1'b0, den_mag}) begin
                partial = partial - {1'b0, den_mag};
                quot[i] = 1'b1;
            end
        end
        if (dividend[WIDTH-1] != divisor[WIDTH-1]) begin
            quot = -quot;
        end
        return quot;
    endfunction

    class quotient_scoreboard;
        division_t awaited[$];
        int errors = 0;
        int n_divisions = 0;
        int n_by_zero = 0;
        int n_overflow = 0;
        int n_negative = 0;

        function void note_operands(logic [WIDTH-1:0] dividend, logic [WIDTH-1:0] divisor);
            division_t d;
            d.dividend = dividend;
            d.divisor = divisor;
            d.quotient = divide_toward_zero(dividend, divisor);
            awaited.push_back(d);
            n_divisions++;
            if (divisor == '0) n_by_zero++;
            if (dividend == MOST_NEG && divisor == MINUS_ONE) n_overflow++;
            if (d.quotient[WIDTH-1]) n_negative++;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_quotient(logic [M_DATA_W-1:0] beat);
            division_t d;
            if (awaited.size() == 0) begin
                report_mismatch($sformatf("quotient %0d with no division pending",
                                          $signed(beat[WIDTH-1:0])));
            end else begin
                d = awaited.pop_front();
                if (beat[WIDTH-1:0] !== d.quotient) begin
                    report_mismatch($sformatf("%0d / %0d gave %0d, expected %0d",
                                              $signed(d.dividend), $signed(d.divisor),
                                              $signed(beat[WIDTH-1:0]),
                                              $signed(d.quotient)));
                end
            end
        endtask

        function int pending();
            return awaited.size();
        endfunction
    endclass

    quotient_scoreboard sb = new();

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic [WIDTH-1:0] random_sign(logic [WIDTH-1:0] v);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic logic [WIDTH-1:0] special_value();
        case ($urandom_range(0, 5))
            0: return MOST_NEG;
            1: return MOST_POS;
            2: return '0;
            3: return 1;
            4: return MINUS_ONE;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_pair(logic [WIDTH-1:0] dividend, logic [WIDTH-1:0] divisor);
        int gap;
        s_tdata <= {divisor, dividend};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_operands(dividend, divisor);
        gap = steady ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_for_quotients();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic send_random_pair();
        logic [WIDTH-1:0] dividend;
        logic [WIDTH-1:0] divisor;
        case ($urandom_range(0, 7))
            0, 1, 2: begin
                dividend = $urandom;
                divisor = $urandom;
            end
            3: begin
                dividend = $urandom;
                divisor = random_sign($urandom_range(0, 15));
            end
            4: begin
                dividend = random_sign($urandom_range(0, 1000));
                divisor = random_sign($urandom_range(1, 50));
            end
            5: begin
                dividend = $urandom;
                divisor = random_sign($urandom >> $urandom_range(0, WIDTH - 1));
            end
            6: begin
                dividend = special_value();
                divisor = special_value();
            end
            default: begin
                // exact multiples, about half of them off by one
                divisor = random_sign($urandom_range(1, 65535));
                dividend = divisor * random_sign($urandom_range(0, 32767))
                           + $urandom_range(0, 1);
            end
        endcase
        send_pair(dividend, divisor);
    endtask

    // result side: random stalls unless the current block runs steady
    initial begin
        int stall;
        stall = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (m_tvalid && m_tready) sb.check_quotient(m_tdata);
            if (stall > 0) begin
                stall--;
                m_tready <= 1'b0;
            end else begin
                stall = steady ? 0 : pick_gap();
                m_tready <= (stall == 0);
                if (stall > 0) stall--;
            end
            @(posedge aclk);
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timed out after %0d cycles with %0d quotients outstanding",
                 cycles, sb.pending());
        $display("signed_restoring_divider_unit_tb: errors");
        $finish;
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes, signs, division by zero and the overflow case
        send_pair(0, 1);
        send_pair(1, 1);
        send_pair(MINUS_ONE, 1);
        send_pair(MOST_POS, 1);
        send_pair(MOST_NEG, 1);
        send_pair(MOST_NEG, MINUS_ONE);
        send_pair(MOST_NEG, 0);
        send_pair(5, 0);
        send_pair(0, 0);
        send_pair(-7, 0);
        send_pair(MOST_POS, MINUS_ONE);
        send_pair(MOST_NEG, MOST_NEG);
        send_pair(MOST_POS, MOST_POS);
        send_pair(MOST_POS, MOST_NEG);
        send_pair(MOST_NEG, MOST_POS);
        send_pair(7, 2);
        send_pair(-7, 2);
        send_pair(7, -2);
        send_pair(-7, -2);
        send_pair(1, MOST_NEG);
        send_pair(MINUS_ONE, MINUS_ONE);
        send_pair(MOST_NEG, 2);
        send_pair(MOST_POS, 2);
        send_pair(12345678, -3);
        wait_for_quotients();

        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n % BLOCK_PAIRS == 0) begin
                steady = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 2) == 0) wait_for_quotients();
            end
            send_random_pair();
        end
        s_tvalid <= 1'b0;

        steady = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (WIDTH + 10) @(posedge aclk);

        $display("%0d divisions checked: %0d by zero, %0d overflowing, %0d negative quotients",
                 sb.n_divisions, sb.n_by_zero, sb.n_overflow, sb.n_negative);
        $display("both channels ran with random stalls and stall-free stretches");
        if (sb.errors == 0) begin
            $display("signed_restoring_divider_unit_tb: clean");
        end else begin
            $display("signed_restoring_divider_unit_tb: errors");
        end
        $finish;
    end

endmodule
